// ===== rtl/crlf_pkg.sv =====
`default_nettype none
package crlf_pkg;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_DOT = 8'h2E;

   // Most bytes one input beat can cause
   localparam int RUN_MAX     = 3;
   localparam int RUN_CNT_W   = $clog2(RUN_MAX + 1);
   localparam int RUN_IDX_W   = $clog2(RUN_MAX);

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_DECODE_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DOT_MODE         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCE_FINAL_CRLF = 2'd2;

   typedef struct packed {
      logic decode_mode;
      logic dot_mode;
      logic force_final_crlf;
   } cfg_type;

   typedef struct packed {
      logic [RUN_CNT_W-1:0]           count;
      logic [RUN_MAX-1:0][7:0]        bytes;
   } run_type;

endpackage
`default_nettype wire

// ===== rtl/crlf_ifs.sv =====
`default_nettype none
interface crlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_end;

   modport source (output valid, output data_byte, output is_end, input ready);
   modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface crlf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface crlf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [crlf_pkg::CSR_INDEX_W-1:0] index;
   logic                             data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/crlf_front.sv =====
`default_nettype none
module crlf_front (
   input  wire                     clock,
   input  wire                     reset,
   input  crlf_pkg::cfg_type       cfg,
   crlf_req_if.sink                req,
   input  wire                     q_full,
   output logic                    q_push,
   output crlf_pkg::run_type       q_data
);

   logic cr_pending_ff, cr_pending_in;
   logic at_line_start_ff, at_line_start_in;
   logic drop_next_dot_ff, drop_next_dot_in;
   logic last_lf_ff, last_lf_in;

   logic                                 accept;
   logic [crlf_pkg::RUN_CNT_W-1:0]       cnt;
   logic [crlf_pkg::RUN_MAX-1:0][7:0]    bytes;
   logic [7:0]                           b;
   logic                                 lf_t;
   logic                                 als_t;
   logic                                 done;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign b         = req.data_byte;

   always_comb begin
      cnt              = '0;
      bytes            = '0;
      lf_t             = last_lf_ff;
      als_t            = at_line_start_ff;
      done             = 1'b0;
      cr_pending_in    = cr_pending_ff;
      at_line_start_in = at_line_start_ff;
      drop_next_dot_in = drop_next_dot_ff;
      last_lf_in       = last_lf_ff;

      if (req.is_end) begin
         // flush, then return to the start-of-stream state
         if (!cfg.decode_mode) begin
            if (cr_pending_ff && !at_line_start_ff) begin
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_LF;
               cnt  = cnt + 1'b1;
               lf_t = 1'b1;
            end
            if (cfg.force_final_crlf && !lf_t) begin
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_CR;
               cnt = cnt + 1'b1;
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_LF;
               cnt = cnt + 1'b1;
            end
         end
         cr_pending_in    = 1'b0;
         at_line_start_in = 1'b1;
         drop_next_dot_in = 1'b0;
         last_lf_in       = 1'b0;
      end else if (cfg.decode_mode) begin
         drop_next_dot_in = 1'b0;
         // drop the second dot of a line-start pair
         if (!(drop_next_dot_ff && b == crlf_pkg::CH_DOT)) begin
            if (b == crlf_pkg::CH_CR) begin
               cr_pending_in    = 1'b1;
               at_line_start_in = 1'b0;
            end else begin
               if (cr_pending_ff) begin
                  cr_pending_in = 1'b0;
                  if (b == crlf_pkg::CH_LF) begin
                     at_line_start_in = 1'b1;
                     bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_LF;
                     cnt  = cnt + 1'b1;
                     done = 1'b1;
                  end else begin
                     bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_CR;
                     cnt = cnt + 1'b1;
                  end
               end
               if (!done) begin
                  bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = b;
                  cnt = cnt + 1'b1;
                  if (cfg.dot_mode && b == crlf_pkg::CH_DOT && at_line_start_ff) begin
                     drop_next_dot_in = 1'b1;
                  end
                  at_line_start_in = 1'b0;
               end
            end
         end
      end else begin
         if (b == crlf_pkg::CH_CR) begin
            // CR after bare CR: finish the earlier line first
            if (cr_pending_ff && !at_line_start_ff) begin
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_LF;
               cnt = cnt + 1'b1;
            end
            cr_pending_in    = 1'b1;
            at_line_start_in = 1'b0;
         end else if (b == crlf_pkg::CH_LF) begin
            at_line_start_in = 1'b1;
            if (!cr_pending_ff) begin
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_CR;
               cnt = cnt + 1'b1;
            end
            cr_pending_in = 1'b0;
         end else begin
            als_t = at_line_start_ff || cr_pending_ff;
            if (cr_pending_ff && !at_line_start_ff) begin
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_LF;
               cnt = cnt + 1'b1;
            end
            if (cfg.dot_mode && b == crlf_pkg::CH_DOT && als_t) begin
               bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = crlf_pkg::CH_DOT;
               cnt = cnt + 1'b1;
            end
            cr_pending_in    = 1'b0;
            at_line_start_in = 1'b0;
         end
         bytes[cnt[crlf_pkg::RUN_IDX_W-1:0]] = b;
         cnt        = cnt + 1'b1;
         last_lf_in = (b == crlf_pkg::CH_LF);
      end
   end

   assign q_push       = accept && (cnt != '0);
   assign q_data.count = cnt;
   assign q_data.bytes = bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_pending_ff    <= 1'b0;
         at_line_start_ff <= 1'b1;
         drop_next_dot_ff <= 1'b0;
         last_lf_ff       <= 1'b0;
      end else if (accept) begin
         cr_pending_ff    <= cr_pending_in;
         at_line_start_ff <= at_line_start_in;
         drop_next_dot_ff <= drop_next_dot_in;
         last_lf_ff       <= last_lf_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/crlf_queue.sv =====
`default_nettype none
module crlf_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  crlf_pkg::run_type   push_data,
   output logic                full,
   input  wire                 pop,
   output crlf_pkg::run_type   head,
   output logic                not_empty
);

   localparam int Depth = crlf_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   crlf_pkg::run_type entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/crlf_back.sv =====
`default_nettype none
module crlf_back (
   input  wire                 clock,
   input  wire                 reset,
   input  crlf_pkg::run_type   head,
   input  wire                 q_not_empty,
   output logic                q_pop,
   crlf_rsp_if.source          rsp
);

   localparam int CntW = crlf_pkg::RUN_CNT_W;

   logic                           valid_ff, valid_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic [crlf_pkg::RUN_IDX_W-1:0] idx_ff, idx_in;
   logic                           load;
   logic                           at_last;

   // refill the output register when it is empty or being taken
   assign load    = !valid_ff || rsp.ready;
   assign at_last = (CntW'(idx_ff) == head.count - 1'b1);
   assign q_pop   = load && q_not_empty && at_last;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = q_not_empty;
         byte_in  = head.bytes[idx_ff];
         last_in  = at_last;
         if (q_not_empty) begin
            idx_in = at_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.last_of_run = last_ff;

endmodule
`default_nettype wire

// ===== rtl/crlf_canonicalizer_dot_stuffing_unit.sv =====
`default_nettype none
// CRLF line-ending converter with optional SMTP dot-stuffing. Encode mode
// turns bare LF and bare CR into CRLF and can double a dot at line start;
// decode mode turns CRLF into LF, drops a CR followed by CR and can undo
// dot-stuffing. A beat with is_end set flushes the stream and restarts it.
// The front end classifies one input beat per cycle, while the queue is not
// full, into a run of zero to three output bytes and writes each non-empty
// run into a two-entry queue; the back end drains the queue one byte per
// cycle, while the output is taken, into an output register, marking the
// last byte of each run with last_of_run. Sustained rate is one input beat
// per cycle while each beat yields at most one byte and the output is not
// stalled; a beat yielding more bytes keeps the output busy for each of its
// bytes, and the queue absorbs that until it fills. Configuration writes are
// accepted at any time but belong to idle periods; csr.ready is always high.
module crlf_canonicalizer_dot_stuffing_unit (
   input  wire          clock,
   input  wire          reset,
   crlf_req_if.sink     req_bus,
   crlf_rsp_if.source   rsp_bus,
   crlf_csr_if.sink     csr_bus
);

   crlf_pkg::cfg_type cfg_ff;
   crlf_pkg::run_type push_data;
   crlf_pkg::run_type head;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_not_empty;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            crlf_pkg::REG_DECODE_MODE:      cfg_ff.decode_mode      <= csr_bus.data;
            crlf_pkg::REG_DOT_MODE:         cfg_ff.dot_mode         <= csr_bus.data;
            crlf_pkg::REG_FORCE_FINAL_CRLF: cfg_ff.force_final_crlf <= csr_bus.data;
            default:                        cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   crlf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_bus),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   crlf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .not_empty (q_not_empty)
   );

   crlf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_not_empty (q_not_empty),
      .q_pop       (q_pop),
      .rsp         (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 150;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crlf_req_if req_bus ();
   crlf_rsp_if rsp_bus ();
   crlf_csr_if csr_bus ();

   crlf_canonicalizer_dot_stuffing_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // Line converter state as the block should hold it
   crlf_pkg::cfg_type model_cfg;
   logic      pend_cr;
   logic      line_begin;
   logic      skip_dot;
   logic      prev_was_lf;
   logic [7:0] run_buf [0:2];
   int        run_len;

   out_char_type expected_chars [$];
   out_char_type oldest_char;
   int        errors = 0;
   int        idle_cycles = 0;
   int        rsp_hold_cycles = 0;
   bit        req_idle_en = 1'b1;
   bit        rsp_idle_en = 1'b1;

   function automatic void add_char(input logic [7:0] c);
      run_buf[run_len] = c;
      run_len++;
   endfunction

   function automatic void clear_line_state();
      pend_cr     = 1'b0;
      line_begin  = 1'b1;
      skip_dot    = 1'b0;
      prev_was_lf = 1'b0;
   endfunction

   function automatic void predict_encode(input logic [7:0] b);
      if (b == crlf_pkg::CH_CR) begin
         if (pend_cr && !line_begin) add_char(crlf_pkg::CH_LF);
         pend_cr    = 1'b1;
         line_begin = 1'b0;
      end else if (b == crlf_pkg::CH_LF) begin
         line_begin = 1'b1;
         if (!pend_cr) add_char(crlf_pkg::CH_CR);
         pend_cr = 1'b0;
      end else begin
         if (pend_cr && !line_begin) begin
            line_begin = 1'b1;
            add_char(crlf_pkg::CH_LF);
         end
         if (model_cfg.dot_mode && b == crlf_pkg::CH_DOT && line_begin)
            add_char(crlf_pkg::CH_DOT);
         pend_cr    = 1'b0;
         line_begin = 1'b0;
      end
      add_char(b);
      prev_was_lf = (b == crlf_pkg::CH_LF);
   endfunction

   function automatic void predict_decode(input logic [7:0] b);
      logic dropped;
      dropped = 1'b0;
      if (skip_dot) begin
         skip_dot = 1'b0;
         dropped  = (b == crlf_pkg::CH_DOT);
      end
      if (!dropped) begin
         if (b == crlf_pkg::CH_CR) begin
            pend_cr    = 1'b1;
            line_begin = 1'b0;
         end else if (pend_cr && b == crlf_pkg::CH_LF) begin
            pend_cr    = 1'b0;
            line_begin = 1'b1;
            add_char(crlf_pkg::CH_LF);
         end else begin
            if (pend_cr) begin
               pend_cr = 1'b0;
               add_char(crlf_pkg::CH_CR);
            end
            add_char(b);
            if (model_cfg.dot_mode && b == crlf_pkg::CH_DOT && line_begin) skip_dot = 1'b1;
            line_begin = 1'b0;
         end
      end
   endfunction

   function automatic void predict_flush();
      if (!model_cfg.decode_mode) begin
         if (pend_cr && !line_begin) begin
            add_char(crlf_pkg::CH_LF);
            prev_was_lf = 1'b1;
         end
         if (model_cfg.force_final_crlf && !prev_was_lf) begin
            add_char(crlf_pkg::CH_CR);
            add_char(crlf_pkg::CH_LF);
         end
      end
      clear_line_state();
   endfunction

   // Queue the output bytes one input beat should produce
   function automatic void predict_beat(input logic [7:0] b, input logic e);
      out_char_type oc;
      run_len = 0;
      if (e) predict_flush();
      else if (model_cfg.decode_mode) predict_decode(b);
      else predict_encode(b);
      for (int i = 0; i < run_len; i++) begin
         oc.ch   = run_buf[i];
         oc.last = (i == run_len - 1);
         expected_chars.push_back(oc);
      end
   endfunction

   initial begin
      model_cfg = '0;
      clear_line_state();
   end

   // Predict on accepted input and config beats, then check the output beat
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               crlf_pkg::REG_DECODE_MODE:      model_cfg.decode_mode      = csr_bus.data;
               crlf_pkg::REG_DOT_MODE:         model_cfg.dot_mode         = csr_bus.data;
               crlf_pkg::REG_FORCE_FINAL_CRLF: model_cfg.force_final_crlf = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            predict_beat(req_bus.data_byte, req_bus.is_end);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: output beat expected none actual out_byte %h last_of_run %b",
                        $time, rsp_bus.out_byte, rsp_bus.last_of_run);
               errors++;
            end else begin
               oldest_char = expected_chars.pop_front();
               if (oldest_char.ch !== rsp_bus.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h",
                           $time, oldest_char.ch, rsp_bus.out_byte);
                  errors++;
               end
               if (oldest_char.last !== rsp_bus.last_of_run) begin
                  $display("%0t: last_of_run expected %b actual %b",
                           $time, oldest_char.last, rsp_bus.last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Output side: random stalls, plus a long hold on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles - 1) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end
      end
   end

   // Leave valid high after the beat; the next call or an idle step decides
   task automatic send_beat(input logic [7:0] b, input logic e);
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.is_end    <= e;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic csr_write(input logic [crlf_pkg::CSR_INDEX_W-1:0] idx, input logic d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic set_config(input logic dec, input logic dot, input logic ffc);
      csr_write(crlf_pkg::REG_DECODE_MODE, dec);
      csr_write(crlf_pkg::REG_DOT_MODE, dot);
      csr_write(crlf_pkg::REG_FORCE_FINAL_CRLF, ffc);
      csr_bus.valid <= 1'b0;
   endtask

   // Stop offering, wait for every predicted byte, then let the pipe empty
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 4))
         0:       return crlf_pkg::CH_CR;
         1:       return crlf_pkg::CH_LF;
         2:       return crlf_pkg::CH_DOT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly lines (leading dots, body, some line ending), some noise and ends
   task automatic send_random_text(input int n);
      int sent;
      int k;
      sent = 0;
      while (sent < n) begin
         k = $urandom_range(0, 9);
         if (k < 7) begin
            repeat ($urandom_range(0, 2)) begin
               send_beat(crlf_pkg::CH_DOT, 1'b0);
               sent++;
            end
            repeat ($urandom_range(0, 5)) begin
               send_beat(8'($urandom_range(0, 255)), 1'b0);
               sent++;
            end
            case ($urandom_range(0, 3))
               0, 1: begin
                  send_beat(crlf_pkg::CH_CR, 1'b0);
                  send_beat(crlf_pkg::CH_LF, 1'b0);
                  sent += 2;
               end
               2: begin
                  send_beat(crlf_pkg::CH_LF, 1'b0);
                  sent++;
               end
               default: begin
                  send_beat(crlf_pkg::CH_CR, 1'b0);
                  sent++;
               end
            endcase
         end else if (k < 9) begin
            send_beat(noise_char(), 1'b0);
            sent++;
         end else begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
            sent++;
         end
      end
   endtask

   task automatic test_encode_directed();
      set_config(1'b0, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1);                  // empty stream still gets CRLF
      send_beat(crlf_pkg::CH_DOT, 1'b0);       // line-start dot doubled
      send_beat(8'h00, 1'b0);
      send_beat(crlf_pkg::CH_CR, 1'b0);
      send_beat(crlf_pkg::CH_CR, 1'b0);        // CR CR gives CR LF CR
      send_beat(crlf_pkg::CH_DOT, 1'b0);
      send_beat(crlf_pkg::CH_LF, 1'b0);
      send_beat(crlf_pkg::CH_LF, 1'b0);        // bare LF
      send_beat(8'hFF, 1'b0);
      send_beat(crlf_pkg::CH_CR, 1'b0);
      send_beat(8'hA5, 1'b1);                  // pending CR completed at end
      send_beat(8'h7A, 1'b0);
      send_beat(8'h5A, 1'b1);                  // final CRLF appended
      send_beat(crlf_pkg::CH_LF, 1'b0);
      send_beat(8'hFF, 1'b1);                  // ends in LF, nothing appended
      wait_drained();
   endtask

   task automatic test_decode_directed();
      set_config(1'b1, 1'b1, 1'b1);
      send_beat(crlf_pkg::CH_DOT, 1'b0);
      send_beat(crlf_pkg::CH_DOT, 1'b0);       // stuffed dot dropped
      send_beat(8'h61, 1'b0);
      send_beat(crlf_pkg::CH_CR, 1'b0);
      send_beat(crlf_pkg::CH_LF, 1'b0);
      send_beat(crlf_pkg::CH_DOT, 1'b0);
      send_beat(8'h62, 1'b0);                  // non-dot after line-start dot kept
      send_beat(crlf_pkg::CH_CR, 1'b0);
      send_beat(crlf_pkg::CH_CR, 1'b0);        // lone CR before CR dropped
      send_beat(crlf_pkg::CH_LF, 1'b0);
      send_beat(crlf_pkg::CH_LF, 1'b0);        // bare LF, no line start
      send_beat(crlf_pkg::CH_DOT, 1'b0);
      send_beat(crlf_pkg::CH_CR, 1'b0);
      send_beat(8'h00, 1'b1);                  // pending CR discarded
      wait_drained();
   endtask

   task automatic test_mode_sweep();
      logic [2:0] m;
      for (int i = 0; i < 8; i++) begin
         m = 3'(i);
         set_config(m[2], m[1], m[0]);
         send_random_text(14);
         wait_drained();
      end
   endtask

   task automatic test_output_backpressure();
      set_config(1'b0, 1'b1, 1'b0);
      req_idle_en = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      // each LF expands to two bytes, so the block fills and stalls input
      repeat (12) begin
         send_beat(crlf_pkg::CH_LF, 1'b0);
         send_beat(crlf_pkg::CH_DOT, 1'b0);
      end
      req_idle_en = 1'b1;
      wait_drained();
   endtask

   task automatic test_drain_pause();
      set_config(1'b1, 1'b0, 1'b0);
      send_random_text(12);
      wait_drained();
      send_random_text(12);
      wait_drained();
   endtask

   task automatic test_unpaced_tail();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      set_config(1'b0, 1'b1, 1'b1);
      send_random_text(20);
      wait_drained();
      set_config(1'b1, 1'b1, 1'b0);
      send_random_text(20);
      wait_drained();
   endtask

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.is_end    <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= crlf_pkg::REG_DECODE_MODE;
      csr_bus.data      <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_encode_directed();
      test_decode_directed();
      test_mode_sweep();
      test_output_backpressure();
      test_drain_pause();
      test_unpaced_tail();

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

// ===== crlf_canonicalizer_dot_stuffing_unit.f =====
rtl/crlf_pkg.sv
rtl/crlf_ifs.sv
rtl/crlf_front.sv
rtl/crlf_queue.sv
rtl/crlf_back.sv
rtl/crlf_canonicalizer_dot_stuffing_unit.sv
tb/sv/testbench.sv
